// ===== sv/obb_sat_pkg.sv =====
package obb_sat_pkg;

	localparam int COORD_BITS = 24;
	localparam int AXIS_W = 24;
	localparam int EXT_W = 23;
	localparam int THR_W = 40;
	localparam int FRAC = 22;
	localparam int LW = 27;
	localparam int DW = 31;
	localparam int MW = 32;
	localparam int PW = 64;
	localparam int OFF_W = COORD_BITS + 1;

	localparam logic [THR_W-1:0] THR_RESET = 40'd1759218604;
	localparam logic [1:0] ROW_CENTER = 2'd3;
	localparam logic [3:0] FACE_AXES = 4'd6;
	localparam logic [3:0] LAST_AXIS = 4'd14;
	localparam logic [3:0] AXIS_NONE = 4'd15;
	localparam logic [5:0] STEP_CROSS = 6'd0;
	localparam logic [5:0] STEP_MID = 6'd12;
	localparam logic [5:0] STEP_PROJ = 6'd13;
	localparam logic [5:0] STEP_LAST = 6'd42;

	typedef struct packed {
		logic              box_select;
		logic [1:0]        row;
		logic signed [23:0] comp_x;
		logic signed [23:0] comp_y;
		logic signed [23:0] comp_z;
		logic [22:0]       half_extent;
		logic              last;
	} item_t;

	typedef struct packed {
		logic       overlap;
		logic [3:0] separating_axis;
	} result_t;

	typedef enum logic [1:0] {A_L, A_STORE, A_DTRUNC} asel_t;
	typedef enum logic [1:0] {B_L, B_STORE, B_EXT, B_OFF} bsel_t;
	typedef enum logic [2:0] {ACC_NONE, ACC_SET, ACC_ADD, ACC_SUB, RCH_SET, RCH_ADD} acc_op_t;
	typedef enum logic [2:0] {WB_NONE, WB_L, WB_LOADL, WB_DTRUNC, WB_DIST} wb_op_t;

	typedef struct packed {
		acc_op_t    acc_op;
		asel_t      a_sel;
		logic [1:0] a_row;
		logic [1:0] a_comp;
		bsel_t      b_sel;
		logic       b_box;
		logic [1:0] b_row;
		logic [1:0] b_comp;
		wb_op_t     wb_op;
		logic [1:0] wb_comp;
	} dp_cmd_t;

	typedef struct packed {
		logic sq_small;
		logic sep;
	} dp_status_t;

	function automatic dp_cmd_t ucode(input logic [3:0] axis, input logic [5:0] step);
		dp_cmd_t c;
		logic [1:0] ia;
		logic [1:0] jb;
		logic [4:0] rel;
		logic [2:0] grp;
		logic [2:0] pgrp;
		logic [1:0] slot;
		c = '0;
		case (axis)
			4'd6: begin ia = 2'd0; jb = 2'd0; end
			4'd7: begin ia = 2'd0; jb = 2'd1; end
			4'd8: begin ia = 2'd0; jb = 2'd2; end
			4'd9: begin ia = 2'd1; jb = 2'd0; end
			4'd10: begin ia = 2'd1; jb = 2'd1; end
			4'd11: begin ia = 2'd1; jb = 2'd2; end
			4'd12: begin ia = 2'd2; jb = 2'd0; end
			4'd13: begin ia = 2'd2; jb = 2'd1; end
			default: begin ia = 2'd2; jb = 2'd2; end
		endcase
		rel = 5'(step - STEP_PROJ);
		grp = rel[4:2];
		slot = rel[1:0];
		pgrp = grp - 3'd1;
		c.a_row = ia;
		c.b_row = jb;
		c.b_box = 1'b1;
		case (step)
			6'd0: begin
				c.acc_op = ACC_SET; c.a_sel = A_STORE; c.a_comp = 2'd1;
				c.b_sel = B_STORE; c.b_comp = 2'd2;
			end
			6'd1: begin
				c.acc_op = ACC_SUB; c.a_sel = A_STORE; c.a_comp = 2'd2;
				c.b_sel = B_STORE; c.b_comp = 2'd1;
			end
			6'd2: begin
				c.acc_op = ACC_SET; c.a_sel = A_STORE; c.a_comp = 2'd2;
				c.b_sel = B_STORE; c.b_comp = 2'd0;
			end
			6'd3: begin
				c.acc_op = ACC_SUB; c.a_sel = A_STORE; c.a_comp = 2'd0;
				c.b_sel = B_STORE; c.b_comp = 2'd2;
				c.wb_op = WB_L; c.wb_comp = 2'd0;
			end
			6'd4: begin
				c.acc_op = ACC_SET; c.a_sel = A_STORE; c.a_comp = 2'd0;
				c.b_sel = B_STORE; c.b_comp = 2'd1;
			end
			6'd5: begin
				c.acc_op = ACC_SUB; c.a_sel = A_STORE; c.a_comp = 2'd1;
				c.b_sel = B_STORE; c.b_comp = 2'd0;
				c.wb_op = WB_L; c.wb_comp = 2'd1;
			end
			6'd6: c.acc_op = ACC_NONE;
			6'd7: begin
				c.wb_op = WB_L; c.wb_comp = 2'd2;
			end
			6'd8, 6'd9, 6'd10: begin
				c.acc_op = (step == 6'd8) ? ACC_SET : ACC_ADD;
				c.a_sel = A_L; c.a_comp = 2'(step - 6'd8);
				c.b_sel = B_L; c.b_comp = 2'(step - 6'd8);
			end
			6'd11: c.acc_op = ACC_NONE;
			6'd12: begin
				if (axis < FACE_AXES) begin
					c.wb_op = WB_LOADL;
					c.b_box = (axis >= 4'd3);
					c.b_row = (axis >= 4'd3) ? 2'(axis - 4'd3) : axis[1:0];
				end
			end
			default: begin
				if (grp <= 3'd5 && slot != 2'd3) begin
					c.acc_op = (slot == 2'd0) ? ACC_SET : ACC_ADD;
					c.a_sel = A_L; c.a_comp = slot;
					c.b_sel = B_STORE; c.b_comp = slot;
					c.b_box = (grp >= 3'd3);
					c.b_row = (grp >= 3'd3) ? 2'(grp - 3'd3) : grp[1:0];
				end else if (grp == 3'd6 && slot != 2'd3) begin
					c.acc_op = (slot == 2'd0) ? ACC_SET : ACC_ADD;
					c.a_sel = A_L; c.a_comp = slot;
					c.b_sel = B_OFF; c.b_comp = slot;
				end else if (grp >= 3'd1 && grp <= 3'd6 && slot == 2'd3) begin
					c.acc_op = (grp == 3'd1) ? RCH_SET : RCH_ADD;
					c.a_sel = A_DTRUNC;
					c.b_sel = B_EXT;
					c.b_box = (pgrp >= 3'd3);
					c.b_row = (pgrp >= 3'd3) ? 2'(pgrp - 3'd3) : pgrp[1:0];
				end
				if (grp >= 3'd1 && grp <= 3'd6 && slot == 2'd0)
					c.wb_op = WB_DTRUNC;
				else if (grp == 3'd7 && slot == 2'd0)
					c.wb_op = WB_DIST;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== sv/obb_sat_dp.sv =====
module obb_sat_dp import obb_sat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  item_t            item,
	input  logic             cfg_wr,
	input  logic [THR_W-1:0] cfg_data,
	input  dp_cmd_t          cmd,
	output dp_status_t       status
);

	logic signed [AXIS_W-1:0]     ax_q [2][3][3];
	logic signed [COORD_BITS-1:0] ctr_q [2][3];
	logic [EXT_W-1:0]             ext_q [2][3];
	logic [THR_W-1:0]             thr_q;
	logic signed [LW-1:0]         l_q [3];
	logic [DW-1:0]                dtr_q;
	logic [PW-1:0]                dist_q;
	logic [PW-1:0]                reach_q;
	logic signed [PW-1:0]         acc_q;
	logic signed [PW-1:0]         prod_s1;
	acc_op_t                      acc_op_s1;
	logic signed [OFF_W-1:0]      off [3];
	logic signed [MW-1:0]         a_op;
	logic signed [MW-1:0]         b_op;
	logic [PW-1:0]                acc_abs;

	always_ff @(posedge clk) begin
		if (wr) begin
			if (item.row == ROW_CENTER) begin
				ctr_q[item.box_select][0] <= item.comp_x[COORD_BITS-1:0];
				ctr_q[item.box_select][1] <= item.comp_y[COORD_BITS-1:0];
				ctr_q[item.box_select][2] <= item.comp_z[COORD_BITS-1:0];
			end else begin
				ax_q[item.box_select][item.row][0] <= item.comp_x;
				ax_q[item.box_select][item.row][1] <= item.comp_y;
				ax_q[item.box_select][item.row][2] <= item.comp_z;
				ext_q[item.box_select][item.row] <= item.half_extent;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			acc_op_s1 <= ACC_NONE;
		end else begin
			if (cfg_wr)
				thr_q <= cfg_data;
			acc_op_s1 <= cmd.acc_op;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++)
			off[c] = OFF_W'(ctr_q[1][c]) - OFF_W'(ctr_q[0][c]);
	end

	always_comb begin
		case (cmd.a_sel)
			A_L:      a_op = MW'(l_q[cmd.a_comp]);
			A_STORE:  a_op = MW'(ax_q[0][cmd.a_row][cmd.a_comp]);
			A_DTRUNC: a_op = signed'(MW'(dtr_q));
			default:  a_op = '0;
		endcase
		case (cmd.b_sel)
			B_L:     b_op = MW'(l_q[cmd.b_comp]);
			B_STORE: b_op = MW'(ax_q[cmd.b_box][cmd.b_row][cmd.b_comp]);
			B_EXT:   b_op = signed'(MW'(ext_q[cmd.b_box][cmd.b_row]));
			B_OFF:   b_op = MW'(off[cmd.b_comp]);
			default: b_op = '0;
		endcase
	end

	assign acc_abs = acc_q[PW-1] ? PW'(-acc_q) : PW'(acc_q);

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(a_op * b_op);
		case (acc_op_s1)
			ACC_SET: acc_q <= prod_s1;
			ACC_ADD: acc_q <= acc_q + prod_s1;
			ACC_SUB: acc_q <= acc_q - prod_s1;
			RCH_SET: reach_q <= PW'(prod_s1);
			RCH_ADD: reach_q <= reach_q + PW'(prod_s1);
			default: ;
		endcase
		case (cmd.wb_op)
			WB_L:      l_q[cmd.wb_comp] <= LW'(acc_q >>> FRAC);
			WB_LOADL: begin
				for (int c = 0; c < 3; c++)
					l_q[c] <= LW'(ax_q[cmd.b_box][cmd.b_row][c]);
			end
			WB_DTRUNC: dtr_q <= DW'(acc_abs >> FRAC);
			WB_DIST:   dist_q <= acc_abs;
			default: ;
		endcase
	end

	assign status.sq_small = PW'(acc_q) < PW'(thr_q);
	assign status.sep = !(dist_q < reach_q);

endmodule

// ===== sv/obb_sat_ctrl.sv =====
module obb_sat_ctrl import obb_sat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_last,
	output logic       item_stall,
	output dp_cmd_t    cmd,
	input  dp_status_t status,
	output logic       result_valid,
	output result_t    result,
	input  logic       result_stall
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t      state_q;
	logic [3:0]  axis_q;
	logic [5:0]  step_q;
	logic [3:0]  sep_q;
	logic        res_valid_q;
	result_t     res_q;
	logic        advance;
	logic [3:0]  axis_nx;

	assign item_stall = (state_q != ST_IDLE);
	assign cmd = (state_q == ST_RUN) ? ucode(axis_q, step_q) : '0;
	assign result_valid = res_valid_q;
	assign result = res_q;
	assign axis_nx = axis_q + 4'd1;
	assign advance = (state_q == ST_RUN) &&
		((step_q == STEP_MID && axis_q >= FACE_AXES && status.sq_small) ||
		 (step_q == STEP_LAST && !status.sep));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= '0;
			step_q <= '0;
			sep_q <= AXIS_NONE;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (state_q == ST_DONE && (!res_valid_q || !result_stall))
				res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid && item_last) begin
						state_q <= ST_RUN;
						axis_q <= '0;
						step_q <= STEP_MID;
					end
				end
				ST_RUN: begin
					if (advance) begin
						if (axis_q == LAST_AXIS) begin
							sep_q <= AXIS_NONE;
							state_q <= ST_DONE;
						end else begin
							axis_q <= axis_nx;
							step_q <= (axis_nx >= FACE_AXES) ? STEP_CROSS : STEP_MID;
						end
					end else if (step_q == STEP_LAST) begin
						sep_q <= axis_q;
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || !result_stall) begin
						res_q.overlap <= (sep_q == AXIS_NONE);
						res_q.separating_axis <= sep_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/obb_separating_axis_test_unit.sv =====
// Rows load one per cycle while idle; a row with last stalls input for the test.
// Test: each face axis, then each cross axis (a degenerate one is skipped), on one MAC,
// stopping at the first separating axis; the outcome is then registered as the result.
// Result is held in an output register; next rows load while it waits.
// Async active-low reset clears control and restores the threshold register.
module obb_separating_axis_test_unit import obb_sat_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [THR_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       wr;

	assign cfg_ready = 1'b1;
	assign wr = item_valid && !item_stall;

	obb_sat_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (wr),
		.item_last    (item.last),
		.item_stall   (item_stall),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

	obb_sat_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.item     (item),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

// ===== sv/obb_sat_chk.sv =====
module obb_sat_chk import obb_sat_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.overlap == (result.separating_axis == AXIS_NONE))
		else $error("overlap flag disagrees with axis index");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.last |=> item_stall)
		else $error("input not stalled during test");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without a test");

endmodule

bind obb_separating_axis_test_unit obb_sat_chk u_chk (.*);
